// ===== hdl/light_score_top_select_core_defines.svh =====
// assertion macros used by light_score_top_select_core
`ifndef LIGHT_SCORE_TOP_SELECT_CORE_DEFINES_SVH
`define LIGHT_SCORE_TOP_SELECT_CORE_DEFINES_SVH

// property that must hold on every clock edge out of reset
`define LST_ASSERT(label, clk_s, rst_s, prop) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define LST_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/lsts_pkg.sv =====
`default_nettype none
package lsts_pkg;

    localparam int unsigned DefaultSlots = 32;
    localparam int unsigned MaxOut = 16;
    localparam int unsigned ScoreW = 8;
    localparam int unsigned ColorW = 54;
    localparam int unsigned PosW = 48;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_POINT   = 2'd0,
        KIND_SPOT    = 2'd1,
        KIND_VECTOR  = 2'd2,
        KIND_AMBIENT = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SREAD,
        ST_SMUL,
        ST_SSUM,
        ST_SDIV,
        ST_SWRITE,
        ST_PREAD,
        ST_PSCAN,
        ST_PEMIT,
        ST_NONE,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic [4:0] slot;
        logic [7:0] score;
        logic       found;
        logic       last;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/light_score_top_select_core.sv =====
// Light table with scoring and top-N selection. Requests arrive on s_axis: tuser carries
// func and light_type, tdata the light and ambient colors, the position and the radius.
// An add or clear request gives no result. A query scores every stored light, using the
// shared bit-serial division for a point light that needs it, then finds each result with
// a pass over the score memory, and s_axis stays stalled until its last result is taken.
// Results carry slot and score in tdata, found in tuser and the end of the query in tlast.
// The table memories need no clearing after reset. max_selected is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while idle, which the block does not
// enforce. Values above 16 act as 16.
`default_nettype none
module light_score_top_select_core
#(
    parameter int unsigned LIGHT_SLOTS = lsts_pkg::DefaultSlots
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // func, light_type
    input  wire logic [3:0]   s_axis_tuser,
    // color_red, color_green, color_blue, ambient_red, ambient_green, ambient_blue,
    // pos_x, pos_y, pos_z, radius
    input  wire logic [119:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // light_slot, score
    output logic [15:0]       m_axis_tdata,
    // found
    output logic              m_axis_tuser,
    output logic              m_axis_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [4:0]   cfg_wr_data
);
    import lsts_pkg::*;
    `include "light_score_top_select_core_defines.svh"

    localparam int unsigned IdxW = $clog2(LIGHT_SLOTS);
    localparam int unsigned CntW = $clog2(LIGHT_SLOTS + 1);

    // light table and score memory
    logic [1:0]        kind_mem [LIGHT_SLOTS];
    logic [ColorW-1:0] color_mem [LIGHT_SLOTS];
    logic [PosW-1:0]   pos_mem [LIGHT_SLOTS];
    logic [15:0]       rad_mem [LIGHT_SLOTS];
    logic [ScoreW-1:0] score_mem [LIGHT_SLOTS];
    logic              taken_reg [LIGHT_SLOTS];

    state_t            st_reg, st_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic [4:0]        maxsel_reg;
    logic [IdxW-1:0]   idx_reg, idx_next;
    logic [CntW-1:0]   scan_reg, scan_next;
    logic [4:0]        nout_reg, nout_next;
    logic [CntW-1:0]   cand_reg, cand_next;
    logic [4:0]        limit;

    logic signed [15:0] cx_reg, cy_reg, cz_reg;
    logic [15:0]        r_reg;
    logic [1:0]         rd_kind;
    logic [ColorW-1:0]  rd_color;
    logic [PosW-1:0]    rd_pos;
    logic [15:0]        rd_rad;
    logic [ScoreW-1:0]  rd_score;

    logic [33:0] dx2_reg, dy2_reg, dz2_reg, s2_reg, r2_reg;
    logic [19:0] w_reg;
    logic [1:0]  kind_reg;
    logic [35:0] d2_reg;
    logic [7:0]  sc_reg, sc_next;
    logic        div_start, div_done;
    logic        sdiv_first_reg;
    logic        div_start_reg;
    logic        need_div;
    logic [38:0] div_num_reg;
    logic [31:0] div_den_reg;
    logic [7:0]  div_q;

    logic [7:0]      best_sc_reg, best_sc_next;
    logic [IdxW-1:0] best_reg, best_next;
    logic            scan_vld_reg;
    logic [IdxW-1:0] scan_idx_reg;

    result_t out_reg, out_next;
    logic    ovld_reg, ovld_next;

    logic               in_fire, wr_en;
    func_t              func;
    logic signed [16:0] dxs, dys, dzs;
    logic [16:0]        ssum;
    logic [35:0]        mterm;
    logic [18:0]        wprod;
    logic [7:0]         wscore;
    logic               set_taken;
    logic               out_free;
    logic               last_light;
    logic               emit_last;

    assign s_axis_tready = (st_reg == ST_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign func = func_t'(s_axis_tuser[1:0]);
    assign limit = (maxsel_reg > 5'(MaxOut)) ? 5'(MaxOut) : maxsel_reg;
    assign wr_en = in_fire && (func == FUNC_ADD) && (count_reg < CntW'(LIGHT_SLOTS));
    assign out_free = !ovld_reg || m_axis_tready;
    assign last_light = (CntW'(idx_reg) + CntW'(1) == count_reg);
    assign emit_last = (nout_reg + 5'd1 == limit) || (cand_reg == CntW'(1));
    assign need_div = (kind_reg == KIND_POINT) && !(d2_reg > 36'(s2_reg)) && (r2_reg != '0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kind_mem[count_reg[IdxW-1:0]] <= s_axis_tuser[3:2];
            color_mem[count_reg[IdxW-1:0]] <= s_axis_tdata[53:0];
            pos_mem[count_reg[IdxW-1:0]] <= s_axis_tdata[101:54];
            rad_mem[count_reg[IdxW-1:0]] <= s_axis_tdata[117:102];
        end
        rd_kind <= kind_mem[idx_reg];
        rd_color <= color_mem[idx_reg];
        rd_pos <= pos_mem[idx_reg];
        rd_rad <= rad_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_SWRITE)
        begin
            score_mem[idx_reg] <= sc_reg;
        end
        rd_score <= score_mem[scan_reg[IdxW-1:0]];
    end

    // scoring datapath
    always_comb
    begin
        dxs = 17'($signed(rd_pos[15:0])) - 17'(cx_reg);
        dys = 17'($signed(rd_pos[31:16])) - 17'(cy_reg);
        dzs = 17'($signed(rd_pos[47:32])) - 17'(cz_reg);
        ssum = 17'(r_reg) + 17'(rd_rad);
        mterm = 36'(s2_reg) - d2_reg;
        if (mterm > 36'(r2_reg))
        begin
            mterm = 36'(r2_reg);
        end
        // floor(w/2560) as floor((w>>9)/5), the divide by 5 as a multiply by 205/1024
        wprod = 19'(w_reg[19:9]) * 19'd205;
        wscore = (w_reg > 20'd256000) ? 8'd200 : 8'd100 + 8'(wprod[18:10]);
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_SMUL)
        begin
            kind_reg <= rd_kind;
            dx2_reg <= $unsigned(34'(dxs * dxs));
            dy2_reg <= $unsigned(34'(dys * dys));
            dz2_reg <= $unsigned(34'(dzs * dzs));
            s2_reg <= 34'(ssum * ssum);
            r2_reg <= 34'(r_reg * r_reg);
            w_reg <= 20'(346 * (10'(rd_color[8:0]) + 10'(rd_color[35:27])));
        end
        if (st_reg == ST_SSUM)
        begin
            d2_reg <= 36'(dx2_reg) + 36'(dy2_reg) + 36'(dz2_reg);
            w_reg <= w_reg
                   + 20'(588 * (10'(rd_color[17:9]) + 10'(rd_color[44:36])))
                   + 20'(70 * (10'(rd_color[26:18]) + 10'(rd_color[53:45])));
        end
        if (st_reg == ST_SDIV && sdiv_first_reg)
        begin
            div_num_reg <= 39'(mterm) * 39'd99;
            div_den_reg <= 32'(r2_reg);
        end
    end

    // divider started once, on the cycle after the operands are loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sdiv_first_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            sdiv_first_reg <= (st_reg == ST_SSUM);
            div_start_reg <= (st_reg == ST_SDIV) && sdiv_first_reg && need_div;
        end
    end
    assign div_start = div_start_reg;

    lsts_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num_reg),
        .divisor  (div_den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (in_fire && func == FUNC_QUERY)
                begin
                    st_next = (count_reg == '0) ? ST_PREAD : ST_SREAD;
                end
            end
            ST_SREAD: st_next = ST_SMUL;
            ST_SMUL: st_next = ST_SSUM;
            ST_SSUM: st_next = ST_SDIV;
            ST_SDIV:
            begin
                if (!need_div || div_done)
                begin
                    st_next = ST_SWRITE;
                end
            end
            ST_SWRITE: st_next = last_light ? ST_PREAD : ST_SREAD;
            ST_PREAD: st_next = (nout_reg >= limit || count_reg == '0) ? ST_NONE : ST_PSCAN;
            ST_PSCAN:
            begin
                if (scan_reg >= count_reg && !scan_vld_reg)
                begin
                    st_next = ST_PEMIT;
                end
            end
            ST_PEMIT:
            begin
                if (best_sc_reg == '0)
                begin
                    st_next = ST_NONE;
                end
                else if (out_free)
                begin
                    st_next = emit_last ? ST_WAIT : ST_PREAD;
                end
            end
            ST_NONE:
            begin
                if (nout_reg != '0 || out_free)
                begin
                    st_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // counters, scores and results
    always_comb
    begin
        count_next = count_reg;
        idx_next = idx_reg;
        scan_next = scan_reg;
        nout_next = nout_reg;
        cand_next = cand_reg;
        sc_next = sc_reg;
        best_sc_next = best_sc_reg;
        best_next = best_reg;
        out_next = out_reg;
        ovld_next = ovld_reg;
        set_taken = 1'b0;
        if (ovld_reg && m_axis_tready)
        begin
            ovld_next = 1'b0;
        end
        case (st_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (wr_en)
                    begin
                        count_next = count_reg + CntW'(1);
                    end
                    if (func == FUNC_CLEAR)
                    begin
                        count_next = '0;
                    end
                    if (func == FUNC_QUERY)
                    begin
                        idx_next = '0;
                        nout_next = '0;
                    end
                end
            end
            ST_SDIV:
            begin
                if (kind_reg == KIND_VECTOR || kind_reg == KIND_AMBIENT)
                begin
                    sc_next = wscore;
                end
                else if (kind_reg == KIND_SPOT)
                begin
                    sc_next = 8'd1;
                end
                else if (d2_reg > 36'(s2_reg))
                begin
                    sc_next = 8'd0;
                end
                else if (r2_reg == '0)
                begin
                    sc_next = 8'd1;
                end
                else
                begin
                    sc_next = 8'd1 + div_q;
                end
            end
            ST_SWRITE:
            begin
                if (!last_light)
                begin
                    idx_next = idx_reg + IdxW'(1);
                end
            end
            ST_PREAD:
            begin
                scan_next = '0;
                best_sc_next = '0;
                best_next = '0;
                cand_next = '0;
            end
            ST_PSCAN:
            begin
                if (scan_vld_reg && !taken_reg[scan_idx_reg])
                begin
                    if (rd_score != '0)
                    begin
                        cand_next = cand_reg + CntW'(1);
                    end
                    if (rd_score > best_sc_reg)
                    begin
                        best_sc_next = rd_score;
                        best_next = scan_idx_reg;
                    end
                end
                if (scan_reg < count_reg)
                begin
                    scan_next = scan_reg + CntW'(1);
                end
            end
            ST_PEMIT:
            begin
                if (best_sc_reg != '0 && out_free)
                begin
                    set_taken = 1'b1;
                    out_next.slot = 5'(best_reg);
                    out_next.score = best_sc_reg;
                    out_next.found = 1'b1;
                    out_next.last = emit_last;
                    ovld_next = 1'b1;
                    nout_next = nout_reg + 5'd1;
                end
            end
            ST_NONE:
            begin
                if (nout_reg == '0 && out_free)
                begin
                    out_next = '{slot: '0, score: '0, found: 1'b0, last: 1'b1};
                    ovld_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            count_reg <= '0;
            maxsel_reg <= 5'd8;
            ovld_reg <= 1'b0;
            nout_reg <= '0;
            scan_vld_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                maxsel_reg <= cfg_wr_data;
            end
            ovld_reg <= ovld_next;
            nout_reg <= nout_next;
            scan_vld_reg <= (st_reg == ST_PSCAN) && (scan_reg < count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        scan_reg <= scan_next;
        scan_idx_reg <= scan_reg[IdxW-1:0];
        cand_reg <= cand_next;
        sc_reg <= sc_next;
        best_sc_reg <= best_sc_next;
        best_reg <= best_next;
        out_reg <= out_next;
        if (in_fire && func == FUNC_QUERY)
        begin
            cx_reg <= $signed(s_axis_tdata[69:54]);
            cy_reg <= $signed(s_axis_tdata[85:70]);
            cz_reg <= $signed(s_axis_tdata[101:86]);
            r_reg <= s_axis_tdata[117:102];
        end
    end

    for (genvar g = 0; g < LIGHT_SLOTS; g++)
    begin : g_taken
        always_ff @(posedge clk)
        begin
            if (st_reg == ST_SWRITE && idx_reg == IdxW'(g))
            begin
                taken_reg[g] <= 1'b0;
            end
            else if (set_taken && best_reg == IdxW'(g))
            begin
                taken_reg[g] <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata = {3'b000, out_reg.score, out_reg.slot};
    assign m_axis_tuser = out_reg.found;
    assign m_axis_tlast = out_reg.last;

    `LST_ASSERT(a_count_range, clk, rst_n, count_reg <= CntW'(LIGHT_SLOTS))
    `LST_ASSERT(a_busy_no_ready, clk, rst_n, (st_reg == ST_IDLE) || !s_axis_tready)
    `LST_ASSERT_NEXT(a_emit_valid, clk, rst_n, set_taken, ovld_reg)
    `LST_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
`default_nettype wire

// ===== hdl/lsts_divider.sv =====
`default_nettype none
module lsts_divider
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [38:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [7:0]       quotient
);
    import lsts_pkg::*;

    // restoring division, one quotient bit per cycle; result is below 100
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [38:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [7:0]  q_reg, q_next;
    logic        done_reg, done_next;
    logic [39:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        q_next = q_reg;
        done_next = 1'b0;
        trial = {1'b0, rem_reg} - ({8'd0, dvs_reg} << cnt_reg[2:0]);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 7'd6;
            rem_next = dividend;
            dvs_next = divisor;
            q_next = '0;
        end
        else if (busy_reg)
        begin
            if (!trial[39])
            begin
                rem_next = trial[38:0];
                q_next = q_reg | (8'd1 << cnt_reg[2:0]);
            end
            if (cnt_reg == 7'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg <= q_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

// ===== test/light_score_top_select_core_tb.sv =====
module light_score_top_select_core_tb;
    import lsts_pkg::*;

    localparam int unsigned SLOTS = 32;
    localparam longint unsigned CYCLE_LIMIT = 3000000;

    typedef struct {
        func_t             func;
        kind_t             kind;
        logic [8:0]        col [6];
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic [15:0]       rad;
    } light_req_t;

    class light_select_scoreboard;
        kind_t             kind_tab [SLOTS];
        logic [8:0]        col_tab [SLOTS][6];
        longint            pos_tab [SLOTS][3];
        longint unsigned   rad_tab [SLOTS];
        int unsigned       count;
        int unsigned       max_sel;
        result_t           pending_results [$];
        int                errors;
        int                seen;
        int                n_add;
        int                n_query;
        int                n_full;

        function new();
            count = 0;
            max_sel = 8;
            errors = 0;
            seen = 0;
            n_add = 0;
            n_query = 0;
            n_full = 0;
        endfunction

        function int unsigned light_rating(int i, longint cx, longint cy, longint cz,
                                           longint unsigned r);
            longint unsigned w;
            longint dx;
            longint dy;
            longint dz;
            longint unsigned d2;
            longint unsigned s2;
            longint unsigned r2;
            longint unsigned m;
            if (kind_tab[i] == KIND_VECTOR || kind_tab[i] == KIND_AMBIENT)
            begin
                w = 346 * (col_tab[i][0] + col_tab[i][3]) + 588 * (col_tab[i][1] + col_tab[i][4])
                  + 70 * (col_tab[i][2] + col_tab[i][5]);
                if (w > 256000)
                    w = 256000;
                return 100 + w / 2560;
            end
            if (kind_tab[i] == KIND_SPOT)
                return 1;
            dx = pos_tab[i][0] - cx;
            dy = pos_tab[i][1] - cy;
            dz = pos_tab[i][2] - cz;
            d2 = dx * dx + dy * dy + dz * dz;
            s2 = (r + rad_tab[i]) * (r + rad_tab[i]);
            r2 = r * r;
            if (d2 > s2)
                return 0;
            if (r2 == 0)
                return 1;
            m = s2 - d2;
            if (m > r2)
                m = r2;
            return 1 + (99 * m) / r2;
        endfunction

        function void note_request(light_req_t q);
            int unsigned scores [SLOTS];
            bit taken [SLOTS];
            int unsigned lim;
            int unsigned n;
            int unsigned best;
            int unsigned best_score;
            result_t res;
            case (q.func)
                FUNC_ADD:
                begin
                    n_add++;
                    if (count >= SLOTS)
                    begin
                        n_full++;
                        return;
                    end
                    kind_tab[count] = q.kind;
                    col_tab[count] = q.col;
                    pos_tab[count][0] = q.px;
                    pos_tab[count][1] = q.py;
                    pos_tab[count][2] = q.pz;
                    rad_tab[count] = q.rad;
                    count++;
                end
                FUNC_CLEAR:
                    count = 0;
                FUNC_QUERY:
                begin
                    n_query++;
                    for (int i = 0; i < count; i++)
                    begin
                        scores[i] = light_rating(i, q.px, q.py, q.pz, q.rad);
                        taken[i] = 0;
                    end
                    lim = (max_sel > MaxOut) ? MaxOut : max_sel;
                    n = 0;
                    while (n < lim)
                    begin
                        best = 0;
                        best_score = 0;
                        for (int i = 0; i < count; i++)
                            if (!taken[i] && scores[i] > best_score)
                            begin
                                best_score = scores[i];
                                best = i;
                            end
                        if (best_score == 0)
                            break;
                        taken[best] = 1;
                        res.slot = best[4:0];
                        res.score = best_score[7:0];
                        res.found = 1'b1;
                        res.last = 1'b0;
                        pending_results = {pending_results, res};
                        n++;
                    end
                    if (n == 0)
                    begin
                        res = '0;
                        res.last = 1'b1;
                        pending_results = {pending_results, res};
                    end
                    else
                        pending_results[pending_results.size() - 1].last = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected nothing, actual %p", $time, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.slot !== want.slot || got.score !== want.score || got.found !== want.found
                || got.last !== want.last)
            begin
                errors++;
                $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [3:0]   s_axis_tuser;
    logic [119:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_wr_en;
    logic [4:0]   cfg_wr_data;

    light_select_scoreboard board;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    bit           recv_hold;
    longint unsigned cycles;

    light_score_top_select_core dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** light_score_top_select_core: FAILED **");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (recv_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.slot = m_axis_tdata[4:0];
            got.score = m_axis_tdata[12:5];
            got.found = m_axis_tuser;
            got.last = m_axis_tlast;
            board.check_result(got);
        end
    end

    function automatic logic [119:0] pack_data(light_req_t q);
        return {2'd0, q.rad, q.pz, q.py, q.px, q.col[5], q.col[4], q.col[3], q.col[2],
                q.col[1], q.col[0]};
    endfunction

    function automatic logic signed [15:0] rand_coord();
        if ($urandom_range(0, 9) < 7)
            return 16'($signed($urandom_range(0, 600)) - 300);
        return 16'($urandom);
    endfunction

    function automatic light_req_t rand_light(func_t f);
        light_req_t q;
        q.func = f;
        q.kind = kind_t'($urandom_range(0, 3));
        for (int k = 0; k < 6; k++)
            q.col[k] = ($urandom_range(0, 9) == 0) ? 9'h1ff : 9'($urandom);
        q.px = rand_coord();
        q.py = rand_coord();
        q.pz = rand_coord();
        case ($urandom_range(0, 9))
            0: q.rad = 16'd0;
            1, 2: q.rad = 16'($urandom);
            default: q.rad = 16'($urandom_range(0, 400));
        endcase
        return q;
    endfunction

    task automatic send_req(light_req_t q);
        if (send_idle_pct > 0)
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                s_axis_tvalid = 1'b0;
                @(negedge clk);
            end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = {q.kind, q.func};
        s_axis_tdata = pack_data(q);
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_request(q);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (board.pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_max_selected(logic [4:0] v);
        drain_results();
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        board.max_sel = v;
    endtask

    task automatic random_phase(int items);
        int r;
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_req(rand_light(FUNC_ADD));
            else if (r < 90)
                send_req(rand_light(FUNC_QUERY));
            else if (r < 95)
                send_req(rand_light(FUNC_CLEAR));
            else
                send_req(rand_light(FUNC_NONE));
        end
    endtask

    task automatic hold_receiver(int n);
        recv_hold = 1'b1;
        repeat (n) @(posedge clk);
        recv_hold = 1'b0;
    endtask

    initial
    begin
        light_req_t q;
        board = new();
        cycles = 0;
        recv_hold = 1'b0;
        send_idle_pct = 14;
        recv_stall_pct = 73;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty table, extremes, every kind, unused code
        q = rand_light(FUNC_QUERY);
        send_req(q);
        q.func = FUNC_ADD;
        q.kind = KIND_POINT;
        q.px = 16'sh7fff;
        q.py = 16'sh7fff;
        q.pz = 16'sh7fff;
        q.rad = 16'hffff;
        send_req(q);
        q.px = -16'sh8000;
        q.py = -16'sh8000;
        q.pz = -16'sh8000;
        q.rad = 16'd0;
        send_req(q);
        q.kind = KIND_SPOT;
        send_req(q);
        q.kind = KIND_VECTOR;
        for (int k = 0; k < 6; k++)
            q.col[k] = 9'h1ff;
        send_req(q);
        q.kind = KIND_AMBIENT;
        for (int k = 0; k < 6; k++)
            q.col[k] = 9'h000;
        send_req(q);
        q.func = FUNC_QUERY;
        q.rad = 16'd0;
        send_req(q);
        q.px = 16'sh7fff;
        q.py = 16'sh7fff;
        q.pz = 16'sh7fff;
        q.rad = 16'hffff;
        send_req(q);
        q.func = FUNC_NONE;
        send_req(q);
        q.func = FUNC_QUERY;
        send_req(q);
        q.func = FUNC_CLEAR;
        send_req(q);
        q.func = FUNC_QUERY;
        send_req(q);

        // table full
        write_max_selected(5'd31);
        for (int i = 0; i < 34; i++)
            send_req(rand_light(FUNC_ADD));
        send_req(rand_light(FUNC_QUERY));
        write_max_selected(5'd0);
        send_req(rand_light(FUNC_QUERY));
        write_max_selected(5'd1);
        send_req(rand_light(FUNC_QUERY));
        send_req(rand_light(FUNC_CLEAR));

        write_max_selected(5'd16);
        random_phase(30);

        // long receiver hold while queries keep coming
        fork
            hold_receiver(600);
            begin
                for (int i = 0; i < 8; i++)
                    send_req(rand_light(FUNC_ADD));
                for (int i = 0; i < 10; i++)
                    send_req(rand_light(FUNC_QUERY));
            end
        join
        drain_results();

        send_idle_pct = 73;
        recv_stall_pct = 14;
        write_max_selected(5'd3);
        random_phase(30);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_max_selected(5'($urandom_range(0, 31)));
        random_phase(30);

        s_axis_tvalid = 1'b0;
        while (board.pending_results.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);

        $display("covered %0d adds (%0d on a full table), %0d queries, %0d results checked",
                 board.n_add, board.n_full, board.n_query, board.seen);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("** light_score_top_select_core: PASSED **");
        else
            $display("** light_score_top_select_core: FAILED **");
        $finish;
    end

endmodule
